[src/trs_pkg.sv]
// ============================================================================
// TRS matrix builder package
// Fixed-point types, row numbers and the rounding step shared by the core.
// ============================================================================
package trs_pkg;

   typedef logic signed [15:0] quat_type;   // Q2.14
   typedef logic signed [15:0] scale_type;  // Q8.8
   typedef logic signed [31:0] q16_type;    // Q16.16
   typedef logic signed [31:0] qprod_type;  // Q4.28 product of two components
   typedef logic signed [33:0] rot_type;    // rotation entry, Q.28
   typedef logic signed [49:0] prod_type;   // rotation times scale, Q.36
   typedef logic        [1:0]  row_type;

   localparam row_type ROW_0    = 2'd0;
   localparam row_type ROW_1    = 2'd1;
   localparam row_type ROW_2    = 2'd2;
   localparam row_type ROW_LAST = 2'd3;

   localparam q16_type ONE_Q16 = 32'sd65536;

   localparam int FRAC_DROP = 20;
   localparam logic signed [50:0] ROUND_BIAS = 51'sd524288;

   // Rounds a Q.36 product to Q16.16, half toward plus infinity. The product
   // stays below 2^48 in magnitude, so the result always lies in range.
   function automatic q16_type round_elem(prod_type p);
      logic signed [50:0] t;
      t = {p[49], p} + ROUND_BIAS;
      return {t[50], t[50:FRAC_DROP]};
   endfunction

endpackage

[src/trs_transform_matrix_builder_core.sv]
// ============================================================================
// TRS model matrix builder
// Builds translation * rotation * scale from a position, an unnormalised
// quaternion and a per-axis scale, and sends the matrix out row by row.
// ============================================================================
//
//   channel  | direction | beat carries
//   ---------+-----------+-------------------------------------------------
//   req_     | in        | quaternion, position and scale of one matrix
//   rsp_     | out       | one matrix row, row_index 0 to 3, last_row on 3
//
// After its request beat is taken, a matrix passes stages 1 to 4 and the row buffer.
// One row leaves per beat; the buffer reloads when empty or as its last row is taken.
// Four register stages (products, rotation sums, scaling, rounding) feed a row buffer.
// Reset clears the valid bits of the stages and the row buffer.
// A stall on rsp_ready ripples back through the stages, which close up any bubbles.
module trs_transform_matrix_builder_core
   import trs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  quat_type  req_quat_w,
   input  quat_type  req_quat_x,
   input  quat_type  req_quat_y,
   input  quat_type  req_quat_z,
   input  q16_type   req_pos_x,
   input  q16_type   req_pos_y,
   input  q16_type   req_pos_z,
   input  scale_type req_scale_x,
   input  scale_type req_scale_y,
   input  scale_type req_scale_z,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output row_type   rsp_row_index,
   output q16_type   rsp_elem_c0,
   output q16_type   rsp_elem_c1,
   output q16_type   rsp_elem_c2,
   output q16_type   rsp_elem_c3,
   output logic      rsp_last_row
);

   // Stage valid bits and advance enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic en1, en2, en3, en4, buf_free, buf_load;

   // Stage 1: component products
   qprod_type aa_ff, bb_ff, cc_ff, dd_ff, bc_ff, ad_ff, bd_ff, ac_ff, cd_ff, ab_ff;
   q16_type   pos1_ff [3];
   scale_type scl1_ff [3];

   // Stage 2: rotation entries
   rot_type   rot_in [3][3];
   rot_type   rot_ff [3][3];
   q16_type   pos2_ff [3];
   scale_type scl2_ff [3];

   // Stage 3: scaled products
   prod_type  prod_ff [3][3];
   q16_type   pos3_ff [3];

   // Stage 4: rounded elements
   q16_type   elem_ff [3][3];
   q16_type   pos4_ff [3];

   // Row buffer
   q16_type   mat_ff  [3][3];
   q16_type   mpos_ff [3];
   row_type   row_ff, row_in;

   logic signed [32:0] d01, d02, d10, d12, d20, d21;

   assign buf_free  = !out_valid_ff || (rsp_ready && row_ff == ROW_LAST);
   assign buf_load  = s4_valid_ff && buf_free;
   assign en4       = !s4_valid_ff || buf_free;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         aa_ff      <= qprod_type'(req_quat_w) * qprod_type'(req_quat_w);
         bb_ff      <= qprod_type'(req_quat_x) * qprod_type'(req_quat_x);
         cc_ff      <= qprod_type'(req_quat_y) * qprod_type'(req_quat_y);
         dd_ff      <= qprod_type'(req_quat_z) * qprod_type'(req_quat_z);
         bc_ff      <= qprod_type'(req_quat_x) * qprod_type'(req_quat_y);
         ad_ff      <= qprod_type'(req_quat_w) * qprod_type'(req_quat_z);
         bd_ff      <= qprod_type'(req_quat_x) * qprod_type'(req_quat_z);
         ac_ff      <= qprod_type'(req_quat_w) * qprod_type'(req_quat_y);
         cd_ff      <= qprod_type'(req_quat_y) * qprod_type'(req_quat_z);
         ab_ff      <= qprod_type'(req_quat_w) * qprod_type'(req_quat_x);
         pos1_ff[0] <= req_pos_x;
         pos1_ff[1] <= req_pos_y;
         pos1_ff[2] <= req_pos_z;
         scl1_ff[0] <= req_scale_x;
         scl1_ff[1] <= req_scale_y;
         scl1_ff[2] <= req_scale_z;
      end
   end

   // Off-diagonal entries are twice a difference or sum of two products.
   always_comb begin
      d01 = {bc_ff[31], bc_ff} - {ad_ff[31], ad_ff};
      d02 = {bd_ff[31], bd_ff} + {ac_ff[31], ac_ff};
      d10 = {bc_ff[31], bc_ff} + {ad_ff[31], ad_ff};
      d12 = {cd_ff[31], cd_ff} - {ab_ff[31], ab_ff};
      d20 = {bd_ff[31], bd_ff} - {ac_ff[31], ac_ff};
      d21 = {cd_ff[31], cd_ff} + {ab_ff[31], ab_ff};
      rot_in[0][0] = {{2{aa_ff[31]}}, aa_ff} + {{2{bb_ff[31]}}, bb_ff}
                   - {{2{cc_ff[31]}}, cc_ff} - {{2{dd_ff[31]}}, dd_ff};
      rot_in[1][1] = {{2{aa_ff[31]}}, aa_ff} - {{2{bb_ff[31]}}, bb_ff}
                   + {{2{cc_ff[31]}}, cc_ff} - {{2{dd_ff[31]}}, dd_ff};
      rot_in[2][2] = {{2{aa_ff[31]}}, aa_ff} - {{2{bb_ff[31]}}, bb_ff}
                   - {{2{cc_ff[31]}}, cc_ff} + {{2{dd_ff[31]}}, dd_ff};
      rot_in[0][1] = {d01, 1'b0};
      rot_in[0][2] = {d02, 1'b0};
      rot_in[1][0] = {d10, 1'b0};
      rot_in[1][2] = {d12, 1'b0};
      rot_in[2][0] = {d20, 1'b0};
      rot_in[2][1] = {d21, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         rot_ff  <= rot_in;
         pos2_ff <= pos1_ff;
         scl2_ff <= scl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= prod_type'(rot_ff[i][j]) * prod_type'(scl2_ff[j]);
            end
         end
         pos3_ff <= pos2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               elem_ff[i][j] <= round_elem(prod_ff[i][j]);
            end
         end
         pos4_ff <= pos3_ff;
      end
   end

   // Row buffer: holds one matrix and hands it out one row per beat.
   always_comb begin
      row_in = row_ff;
      if (buf_load) begin
         row_in = ROW_0;
      end else if (rsp_valid && rsp_ready) begin
         row_in = row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         row_ff       <= ROW_0;
      end else begin
         row_ff <= row_in;
         if (buf_free) out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_load) begin
         mat_ff  <= elem_ff;
         mpos_ff <= pos4_ff;
      end
   end

   always_comb begin
      case (row_ff)
         ROW_0: begin
            rsp_elem_c0 = mat_ff[0][0];
            rsp_elem_c1 = mat_ff[0][1];
            rsp_elem_c2 = mat_ff[0][2];
            rsp_elem_c3 = mpos_ff[0];
         end
         ROW_1: begin
            rsp_elem_c0 = mat_ff[1][0];
            rsp_elem_c1 = mat_ff[1][1];
            rsp_elem_c2 = mat_ff[1][2];
            rsp_elem_c3 = mpos_ff[1];
         end
         ROW_2: begin
            rsp_elem_c0 = mat_ff[2][0];
            rsp_elem_c1 = mat_ff[2][1];
            rsp_elem_c2 = mat_ff[2][2];
            rsp_elem_c3 = mpos_ff[2];
         end
         default: begin
            rsp_elem_c0 = '0;
            rsp_elem_c1 = '0;
            rsp_elem_c2 = '0;
            rsp_elem_c3 = ONE_Q16;
         end
      endcase
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_last_row  = (row_ff == ROW_LAST);

`ifndef ASSERT_OFF
   // A matrix is never cut short: after a beat that is not the last row, another follows.
   a_rows_continue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_row) |=> rsp_valid)
      else $error("row sequence broken before the last row");

   // Rows of one matrix go out in order.
   a_rows_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_row) |=>
      (rsp_row_index == $past(rsp_row_index) + 2'd1))
      else $error("row index did not advance by one");

   // A new matrix starts at row 0.
   a_matrix_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_row) |=> (!rsp_valid || rsp_row_index == ROW_0))
      else $error("matrix did not start at row 0");
`endif

endmodule

[dv/trs_row_checker.sv]
// ============================================================================
// TRS matrix row checker
// Watches the request and row channels of the matrix builder. Every request
// beat taken is turned into the four rows it should produce, worked out
// independently in 64-bit arithmetic. Every row beat taken is then compared
// field by field with the oldest outstanding row.
// ============================================================================
module trs_row_checker
   import trs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  quat_type  req_quat_w,
   input  quat_type  req_quat_x,
   input  quat_type  req_quat_y,
   input  quat_type  req_quat_z,
   input  q16_type   req_pos_x,
   input  q16_type   req_pos_y,
   input  q16_type   req_pos_z,
   input  scale_type req_scale_x,
   input  scale_type req_scale_y,
   input  scale_type req_scale_z,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  row_type   rsp_row_index,
   input  q16_type   rsp_elem_c0,
   input  q16_type   rsp_elem_c1,
   input  q16_type   rsp_elem_c2,
   input  q16_type   rsp_elem_c3,
   input  logic      rsp_last_row,
   output int        mismatch_count,
   output int        rows_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q16_MAX  = 64'sh7FFF_FFFF;
   localparam longint Q16_MIN  = -64'sh8000_0000;
   localparam longint HALF_LSB = 64'sd524288;

   typedef struct {
      row_type row_index;
      q16_type elem [0:3];
      logic    last_row;
   } matrix_row_type;

   matrix_row_type expected_rows [$];

   initial begin
      mismatch_count   = 0;
      rows_outstanding = 0;
   end

   function automatic q16_type scaled_entry(longint rot, longint scl);
      longint prod;
      longint rounded;
      prod    = rot * scl;
      rounded = (prod + HALF_LSB) >>> 20;
      if (rounded > Q16_MAX) begin
         rounded = Q16_MAX;
      end
      if (rounded < Q16_MIN) begin
         rounded = Q16_MIN;
      end
      return q16_type'(rounded);
   endfunction

   task automatic push_matrix_rows();
      longint         a, b, c, d;
      longint         aa, bb, cc, dd, bc, ad, bd, ac, cd, ab;
      longint         rot [0:2][0:2];
      longint         scl [0:2];
      q16_type        pos [0:2];
      matrix_row_type row;
      a = longint'(req_quat_w);
      b = longint'(req_quat_x);
      c = longint'(req_quat_y);
      d = longint'(req_quat_z);
      scl[0] = longint'(req_scale_x);
      scl[1] = longint'(req_scale_y);
      scl[2] = longint'(req_scale_z);
      pos[0] = req_pos_x;
      pos[1] = req_pos_y;
      pos[2] = req_pos_z;
      aa = a * a;
      bb = b * b;
      cc = c * c;
      dd = d * d;
      bc = 2 * b * c;
      ad = 2 * a * d;
      bd = 2 * b * d;
      ac = 2 * a * c;
      cd = 2 * c * d;
      ab = 2 * a * b;
      rot[0][0] = aa + bb - cc - dd;
      rot[0][1] = bc - ad;
      rot[0][2] = bd + ac;
      rot[1][0] = bc + ad;
      rot[1][1] = aa - bb + cc - dd;
      rot[1][2] = cd - ab;
      rot[2][0] = bd - ac;
      rot[2][1] = cd + ab;
      rot[2][2] = aa - bb - cc + dd;
      for (int i = 0; i < 3; i++) begin
         row.row_index = row_type'(i);
         for (int j = 0; j < 3; j++) begin
            row.elem[j] = scaled_entry(rot[i][j], scl[j]);
         end
         row.elem[3]  = pos[i];
         row.last_row = 1'b0;
         expected_rows.push_back(row);
      end
      row.row_index = ROW_LAST;
      row.elem[0]   = '0;
      row.elem[1]   = '0;
      row.elem[2]   = '0;
      row.elem[3]   = ONE_Q16;
      row.last_row  = 1'b1;
      expected_rows.push_back(row);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_row();
      matrix_row_type want;
      if (expected_rows.size() == 0) begin
         $error("row beat with no row outstanding: row_index %0d", rsp_row_index);
         mismatch_count++;
      end else begin
         want = expected_rows.pop_front();
         check_field("row_index", 32'(want.row_index), 32'(rsp_row_index));
         check_field("elem_c0", want.elem[0], rsp_elem_c0);
         check_field("elem_c1", want.elem[1], rsp_elem_c1);
         check_field("elem_c2", want.elem[2], rsp_elem_c2);
         check_field("elem_c3", want.elem[3], rsp_elem_c3);
         check_field("last_row", 32'(want.last_row), 32'(rsp_last_row));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_rows.delete();
      end else begin
         if (req_valid && req_ready) begin
            push_matrix_rows();
         end
         if (rsp_valid && rsp_ready) begin
            check_row();
         end
      end
      rows_outstanding = expected_rows.size();
   end

endmodule

[dv/tb_top.sv]
// ============================================================================
// TRS matrix builder testbench
// Drives position, quaternion and scale beats into the matrix builder, first
// a directed set of corner values and then random ones, with random idling on
// both channels. A checker beside the block predicts and compares every row.
// ============================================================================
module tb_top
   import trs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      quat_type  w, x, y, z;
      q16_type   px, py, pz;
      scale_type sx, sy, sz;
   } trs_request_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   quat_type  req_quat_w = '0;
   quat_type  req_quat_x = '0;
   quat_type  req_quat_y = '0;
   quat_type  req_quat_z = '0;
   q16_type   req_pos_x = '0;
   q16_type   req_pos_y = '0;
   q16_type   req_pos_z = '0;
   scale_type req_scale_x = '0;
   scale_type req_scale_y = '0;
   scale_type req_scale_z = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   row_type   rsp_row_index;
   q16_type   rsp_elem_c0;
   q16_type   rsp_elem_c1;
   q16_type   rsp_elem_c2;
   q16_type   rsp_elem_c3;
   logic      rsp_last_row;
   int        mismatch_count;
   int        rows_outstanding;
   bit        calm_phase = 1'b0;

   trs_transform_matrix_builder_core uut (.*);

   trs_row_checker row_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (calm_phase || pick < 60) begin
         return 0;
      end
      if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic trs_request_type make_request(
      int w, int x, int y, int z, int px, int py, int pz, int sx, int sy, int sz);
      trs_request_type item;
      item.w  = quat_type'(w);
      item.x  = quat_type'(x);
      item.y  = quat_type'(y);
      item.z  = quat_type'(z);
      item.px = q16_type'(px);
      item.py = q16_type'(py);
      item.pz = q16_type'(pz);
      item.sx = scale_type'(sx);
      item.sy = scale_type'(sy);
      item.sz = scale_type'(sz);
      return item;
   endfunction

   function automatic int corner_value();
      int pick;
      pick = $urandom_range(0, 6);
      case (pick)
         0: begin
            return -32768;
         end
         1: begin
            return 32767;
         end
         2: begin
            return -1;
         end
         3: begin
            return 1;
         end
         4: begin
            return 16384;
         end
         5: begin
            return -16384;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic trs_request_type random_request();
      trs_request_type item;
      int              flavour;
      flavour = $urandom_range(0, 99);
      item = make_request($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
      if (flavour < 35) begin
         item.w  = quat_type'($urandom_range(0, 32768) - 16384);
         item.x  = quat_type'($urandom_range(0, 32768) - 16384);
         item.y  = quat_type'($urandom_range(0, 32768) - 16384);
         item.z  = quat_type'($urandom_range(0, 32768) - 16384);
         item.sx = scale_type'($urandom_range(0, 2048) - 1024);
         item.sy = scale_type'($urandom_range(0, 2048) - 1024);
         item.sz = scale_type'($urandom_range(0, 2048) - 1024);
      end else if (flavour < 50) begin
         item.w  = quat_type'(16384);
         item.x  = '0;
         item.y  = '0;
         item.z  = '0;
      end else if (flavour < 65) begin
         item.w  = quat_type'(corner_value());
         item.x  = quat_type'(corner_value());
         item.y  = quat_type'(corner_value());
         item.z  = quat_type'(corner_value());
         item.sx = scale_type'(corner_value());
         item.sy = scale_type'(corner_value());
         item.sz = scale_type'(corner_value());
      end
      return item;
   endfunction

   task automatic drive_matrix(input trs_request_type item);
      int gap;
      req_valid   <= 1'b1;
      req_quat_w  <= item.w;
      req_quat_x  <= item.x;
      req_quat_y  <= item.y;
      req_quat_z  <= item.z;
      req_pos_x   <= item.px;
      req_pos_y   <= item.py;
      req_pos_z   <= item.pz;
      req_scale_x <= item.sx;
      req_scale_y <= item.sy;
      req_scale_z <= item.sz;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall_left = idle_cycles();
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      drive_matrix(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_matrix(make_request(16384, 0, 0, 0, 0, 0, 0, 256, 256, 256));
      drive_matrix(make_request(16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                -1, 256, 256, 256));
      drive_matrix(make_request(-32768, -32768, -32768, -32768, 32'h8000_0000,
                                32'h7FFF_FFFF, 1, -32768, -32768, -32768));
      drive_matrix(make_request(32767, 32767, 32767, 32767, 65536, -65536, 0,
                                32767, 32767, 32767));
      drive_matrix(make_request(-32768, -32768, -32768, -32768, 0, 0, 0,
                                32767, -32768, 32767));
      drive_matrix(make_request(-32768, 0, 0, 0, 0, 0, 0, -32768, 32767, -1));
      drive_matrix(make_request(0, -32768, 0, 0, 0, 0, 0, 32767, -32768, 1));
      drive_matrix(make_request(0, 0, -32768, 0, 0, 0, 0, -32768, -32768, 32767));
      drive_matrix(make_request(0, 0, 0, -32768, 0, 0, 0, 32767, 32767, -32768));
      drive_matrix(make_request(11585, 11585, 0, 0, 131072, 0, 0, 256, 256, 256));
      drive_matrix(make_request(11585, 0, 11585, 0, 0, 131072, 0, 256, 256, 256));
      drive_matrix(make_request(11585, 0, 0, 11585, 0, 0, 131072, 256, 256, 256));
      drive_matrix(make_request(32767, 0, 0, 0, 0, 0, 0, 256, -256, 512));
      drive_matrix(make_request(8192, 8192, 8192, 8192, 0, 0, 0, 512, 512, 512));
      drive_matrix(make_request(0, 512, 512, 0, 0, 0, 0, 1, 1, 1));
      drive_matrix(make_request(0, 512, 512, 0, 0, 0, 0, -1, -1, -1));
      drive_matrix(make_request(1, -1, 1, -1, 1, -1, 1, 1, -1, 1));
      drive_matrix(make_request(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      drive_matrix(make_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                16'hAAAA, 16'h5555, 16'hAAAA));
      drive_matrix(make_request(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                16'h5555, 16'hAAAA, 16'h5555));

      for (int n = 0; n < 360; n++) begin
         if (n % 60 == 0) begin
            calm_phase = ($urandom_range(0, 3) == 0);
         end
         drive_matrix(random_request());
      end
      req_valid <= 1'b0;

      while (rows_outstanding != 0) begin
         @(negedge clock);
      end
      repeat (16) @(negedge clock);
      if (mismatch_count == 0 && rows_outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
